/* rtl/bte_pkg.sv */
// Package: shared constants, codes and types of the binding table engine.
`default_nettype none
package bte_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] MODE_GROUP = 2'd0;
  localparam logic [1:0] MODE_EXT   = 2'd1;

  typedef enum logic [1:0] {
    CMD_BIND   = 2'd0,
    CMD_UNBIND = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [7:0]  src_ep;
    logic [15:0] cluster;
    logic [1:0]  mode;
    logic [15:0] nwk_addr;
    logic [63:0] ieee_addr;
    logic [7:0]  dest_ep;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    slot_t  rd_addr;
    logic   wr_en;
    slot_t  wr_addr;
    entry_t wr_data;
    logic   set_valid;
    logic   clr_valid;
    slot_t  valid_addr;
  } tbl_req_t;

endpackage
`default_nettype wire

/* rtl/bte_in_if.sv */
// Interface: request channel of the binding table engine.
`default_nettype none
interface bte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  src_endpoint;
  logic [15:0] cluster_id;
  logic [1:0]  addr_mode;
  logic [15:0] short_address;
  logic [63:0] long_address;
  logic [7:0]  dest_endpoint;

  modport source (
    output valid, cmd, src_endpoint, cluster_id, addr_mode, short_address,
           long_address, dest_endpoint,
    input  ready
  );
  modport sink (
    input  valid, cmd, src_endpoint, cluster_id, addr_mode, short_address,
           long_address, dest_endpoint,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/bte_out_if.sv */
// Interface: result channel of the binding table engine.
`default_nettype none
interface bte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [3:0]  slot;
  logic [1:0]  found_mode;
  logic [15:0] found_short;
  logic [63:0] found_long;
  logic [7:0]  found_endpoint;

  modport source (
    output valid, status, hit, slot, found_mode, found_short, found_long,
           found_endpoint,
    input  ready
  );
  modport sink (
    input  valid, status, hit, slot, found_mode, found_short, found_long,
           found_endpoint,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/bte_table.sv */
// Table store: entry memory with registered read and per-slot valid flags.
`default_nettype none
module bte_table
  import bte_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tbl_req_t             req,
  output entry_t                    rd_data,
  output logic      [ENTRIES-1:0]   valid_vec
);

  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (req.set_valid) begin
      valid_nxt[req.valid_addr] = 1'b1;
    end
    if (req.clr_valid) begin
      valid_nxt[req.valid_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_data   = rd_data_r;
  assign valid_vec = valid_r;

endmodule
`default_nettype wire

/* rtl/bte_ctrl.sv */
// Controller: slot scan, match tracking, write-back and result register.
`default_nettype none
module bte_ctrl
  import bte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  bte_in_if.sink                  in_if,
  bte_out_if.source               out_if,
  output tbl_req_t                tbl_req,
  input  wire entry_t             rd_data,
  input  wire logic [ENTRIES-1:0] valid_vec
);

  state_t            state_r,     state_nxt;
  logic [1:0]        cmd_r,       cmd_nxt;
  entry_t            ent_r,       ent_nxt;
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;
  logic              cmp_vld_r,   cmp_vld_nxt;
  slot_t             cmp_idx_r,   cmp_idx_nxt;
  logic              ex_fnd_r,    ex_fnd_nxt;
  slot_t             ex_idx_r,    ex_idx_nxt;
  logic              fr_fnd_r,    fr_fnd_nxt;
  slot_t             fr_idx_r,    fr_idx_nxt;
  logic              key_fnd_r,   key_fnd_nxt;
  slot_t             key_idx_r,   key_idx_nxt;
  entry_t            fnd_r,       fnd_nxt;
  logic              ov_r,        ov_nxt;
  logic [1:0]        o_status_r,  o_status_nxt;
  logic              o_hit_r,     o_hit_nxt;
  logic [3:0]        o_slot_r,    o_slot_nxt;
  entry_t            o_ent_r,     o_ent_nxt;

  logic              issue;
  logic              slot_vld;
  logic              key_eq;
  logic              exact;

  assign issue    = (state_r == S_SCAN) && (cnt_r < CNT_W'(ENTRIES));
  assign slot_vld = valid_vec[cmp_idx_r];
  assign key_eq   = slot_vld && (rd_data.src_ep == ent_r.src_ep)
                    && (rd_data.cluster == ent_r.cluster);
  assign exact    = key_eq && (rd_data.mode == ent_r.mode)
                    && (((ent_r.mode == MODE_GROUP)
                         && (rd_data.nwk_addr == ent_r.nwk_addr))
                        || ((ent_r.mode == MODE_EXT)
                         && (rd_data.ieee_addr == ent_r.ieee_addr)
                         && (rd_data.dest_ep == ent_r.dest_ep)));

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    ent_nxt      = ent_r;
    cnt_nxt      = cnt_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    ex_fnd_nxt   = ex_fnd_r;
    ex_idx_nxt   = ex_idx_r;
    fr_fnd_nxt   = fr_fnd_r;
    fr_idx_nxt   = fr_idx_r;
    key_fnd_nxt  = key_fnd_r;
    key_idx_nxt  = key_idx_r;
    fnd_nxt      = fnd_r;
    ov_nxt       = ov_r && !out_if.ready;
    o_status_nxt = o_status_r;
    o_hit_nxt    = o_hit_r;
    o_slot_nxt   = o_slot_r;
    o_ent_nxt    = o_ent_r;
    tbl_req      = '0;
    tbl_req.rd_en   = issue;
    tbl_req.rd_addr = cnt_r[SLOT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt            = in_if.cmd;
          ent_nxt.src_ep     = in_if.src_endpoint;
          ent_nxt.cluster    = in_if.cluster_id;
          ent_nxt.mode       = in_if.addr_mode;
          ent_nxt.nwk_addr   = in_if.short_address;
          ent_nxt.ieee_addr  = in_if.long_address;
          ent_nxt.dest_ep    = in_if.dest_endpoint;
          cnt_nxt            = '0;
          ex_fnd_nxt         = 1'b0;
          fr_fnd_nxt         = 1'b0;
          key_fnd_nxt        = 1'b0;
          state_nxt          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = cnt_r[SLOT_W-1:0];
        end
        if (cmp_vld_r) begin
          if (exact && !ex_fnd_r) begin
            ex_fnd_nxt = 1'b1;
            ex_idx_nxt = cmp_idx_r;
          end
          if (!slot_vld && !fr_fnd_r) begin
            fr_fnd_nxt = 1'b1;
            fr_idx_nxt = cmp_idx_r;
          end
          if (key_eq && !key_fnd_r) begin
            key_fnd_nxt = 1'b1;
            key_idx_nxt = cmp_idx_r;
            fnd_nxt     = rd_data;
          end
          if (cmp_idx_r == SLOT_W'(ENTRIES - 1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt       = 1'b1;
          o_status_nxt = ST_NONE;
          o_hit_nxt    = 1'b0;
          o_slot_nxt   = '0;
          o_ent_nxt    = '0;
          case (cmd_t'(cmd_r))
            CMD_BIND: begin
              if (ex_fnd_r) begin
                o_status_nxt = ST_OK;
                o_slot_nxt   = 4'(ex_idx_r);
              end else if (fr_fnd_r) begin
                o_status_nxt       = ST_OK;
                o_slot_nxt         = 4'(fr_idx_r);
                tbl_req.wr_en      = 1'b1;
                tbl_req.wr_addr    = fr_idx_r;
                tbl_req.wr_data    = ent_r;
                tbl_req.set_valid  = 1'b1;
                tbl_req.valid_addr = fr_idx_r;
              end else begin
                o_status_nxt = ST_FULL;
              end
            end
            CMD_UNBIND: begin
              if (ex_fnd_r) begin
                o_status_nxt       = ST_OK;
                o_slot_nxt         = 4'(ex_idx_r);
                tbl_req.clr_valid  = 1'b1;
                tbl_req.valid_addr = ex_idx_r;
              end
            end
            CMD_LOOKUP: begin
              if (key_fnd_r) begin
                o_status_nxt = ST_OK;
                o_hit_nxt    = 1'b1;
                o_slot_nxt   = 4'(key_idx_r);
                o_ent_nxt    = fnd_r;
              end
            end
            default: begin
              o_status_nxt = ST_NONE;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ent_r      <= ent_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    ex_fnd_r   <= ex_fnd_nxt;
    ex_idx_r   <= ex_idx_nxt;
    fr_fnd_r   <= fr_fnd_nxt;
    fr_idx_r   <= fr_idx_nxt;
    key_fnd_r  <= key_fnd_nxt;
    key_idx_r  <= key_idx_nxt;
    fnd_r      <= fnd_nxt;
    o_status_r <= o_status_nxt;
    o_hit_r    <= o_hit_nxt;
    o_slot_r   <= o_slot_nxt;
    o_ent_r    <= o_ent_nxt;
  end

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = ov_r;
  assign out_if.status         = o_status_r;
  assign out_if.hit            = o_hit_r;
  assign out_if.slot           = o_slot_r;
  assign out_if.found_mode     = o_ent_r.mode;
  assign out_if.found_short    = o_ent_r.nwk_addr;
  assign out_if.found_long     = o_ent_r.ieee_addr;
  assign out_if.found_endpoint = o_ent_r.dest_ep;

endmodule
`default_nettype wire

/* rtl/binding_table_engine_core.sv */
// Top level: binding table engine with bind, unbind and lookup commands.
// The table of ENTRIES bindings lives in one synchronous memory read one slot
// per cycle; valid flags sit in flip-flops and clear at reset, so the engine
// takes requests from the first cycle. Every request scans all slots in order:
// the engine accepts it, scans every slot through the memory read port, then
// writes back and loads the result register once that register is free. Bind
// and lookup report the lowest matching slot; a new binding takes the lowest
// free slot. The result register holds a finished beat while the next request
// is accepted.
`default_nettype none
module binding_table_engine_core
  import bte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bte_in_if.sink     in_if,
  bte_out_if.source  out_if
);

  tbl_req_t           tbl_req;
  entry_t             rd_data;
  logic [ENTRIES-1:0] valid_vec;

  bte_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tbl_req),
    .rd_data   (rd_data),
    .valid_vec (valid_vec)
  );

  bte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .tbl_req   (tbl_req),
    .rd_data   (rd_data),
    .valid_vec (valid_vec)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench: binding table engine checked beat by beat against a slot-level table predictor.
module testbench;
  import bte_pkg::*;

  localparam logic [1:0] CMD_RSVD   = 2'd3;
  localparam logic [1:0] MODE_RSVD2 = 2'd2;
  localparam logic [1:0] MODE_RSVD3 = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int POOL_N      = 16;
  localparam int PARKED_MAX  = 6;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  src_ep;
    logic [15:0] cluster;
    logic [1:0]  mode;
    logic [15:0] nwk_addr;
    logic [63:0] ieee_addr;
    logic [7:0]  dest_ep;
  } bte_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  slot;
    logic [1:0]  mode;
    logic [15:0] nwk_addr;
    logic [63:0] ieee_addr;
    logic [7:0]  dest_ep;
  } bte_result_t;

  logic clk;
  logic rst_n;

  bte_in_if  in_ch ();
  bte_out_if out_ch ();

  binding_table_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  bit           bound_valid [ENTRIES];
  entry_t       bound_entry [ENTRIES];
  bte_result_t  expected_results [$];
  bte_request_t binding_pool [POOL_N];
  int           mismatches  = 0;
  int           idle_cycles = 0;
  bit           no_idle     = 1'b0;
  bit           hold_off    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bte_request_t mk_request(logic [1:0] cmd, logic [7:0] src_ep,
                                              logic [15:0] cluster, logic [1:0] mode,
                                              logic [15:0] nwk_addr,
                                              logic [63:0] ieee_addr, logic [7:0] dest_ep);
    bte_request_t r;
    r.cmd       = cmd;
    r.src_ep    = src_ep;
    r.cluster   = cluster;
    r.mode      = mode;
    r.nwk_addr  = nwk_addr;
    r.ieee_addr = ieee_addr;
    r.dest_ep   = dest_ep;
    return r;
  endfunction

  function automatic bte_request_t rand_fields();
    return mk_request(CMD_BIND, 8'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
                      16'($urandom), {$urandom, $urandom}, 8'($urandom));
  endfunction

  function automatic int exact_binding(bte_request_t r);
    for (int i = 0; i < ENTRIES; i++) begin
      if (bound_valid[i] && bound_entry[i].src_ep == r.src_ep &&
          bound_entry[i].cluster == r.cluster && bound_entry[i].mode == r.mode) begin
        if (r.mode == MODE_GROUP && bound_entry[i].nwk_addr == r.nwk_addr)
          return i;
        if (r.mode == MODE_EXT && bound_entry[i].ieee_addr == r.ieee_addr &&
            bound_entry[i].dest_ep == r.dest_ep)
          return i;
      end
    end
    return -1;
  endfunction

  function automatic int count_bound(bit parked_only);
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (bound_valid[i] && (!parked_only || bound_entry[i].mode[1]))
        n++;
    return n;
  endfunction

  function automatic bte_result_t predict_binding(bte_request_t r);
    bte_result_t res;
    int m;
    res        = '0;
    res.status = ST_NONE;
    m          = -1;
    case (r.cmd)
      CMD_BIND: begin
        m = exact_binding(r);
        if (m >= 0) begin
          res.status = ST_OK;
          res.slot   = m[3:0];
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < ENTRIES; i++)
            if (m < 0 && !bound_valid[i])
              m = i;
          if (m >= 0) begin
            bound_valid[m]           = 1'b1;
            bound_entry[m].src_ep    = r.src_ep;
            bound_entry[m].cluster   = r.cluster;
            bound_entry[m].mode      = r.mode;
            bound_entry[m].nwk_addr  = r.nwk_addr;
            bound_entry[m].ieee_addr = r.ieee_addr;
            bound_entry[m].dest_ep   = r.dest_ep;
            res.status = ST_OK;
            res.slot   = m[3:0];
          end
        end
      end
      CMD_UNBIND: begin
        m = exact_binding(r);
        if (m >= 0) begin
          bound_valid[m] = 1'b0;
          res.status     = ST_OK;
          res.slot       = m[3:0];
        end
      end
      CMD_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++)
          if (m < 0 && bound_valid[i] && bound_entry[i].src_ep == r.src_ep &&
              bound_entry[i].cluster == r.cluster)
            m = i;
        if (m >= 0) begin
          res.status    = ST_OK;
          res.hit       = 1'b1;
          res.slot      = m[3:0];
          res.mode      = bound_entry[m].mode;
          res.nwk_addr  = bound_entry[m].nwk_addr;
          res.ieee_addr = bound_entry[m].ieee_addr;
          res.dest_ep   = bound_entry[m].dest_ep;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    bte_result_t got;
    bte_result_t want;
    bit          moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got = {out_ch.status, out_ch.hit, out_ch.slot, out_ch.found_mode,
               out_ch.found_short, out_ch.found_long, out_ch.found_endpoint};
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 64'(got.slot), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.hit !== want.hit)
            report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.slot !== want.slot)
            report_mismatch("slot", 64'(got.slot), 64'(want.slot));
          if (got.mode !== want.mode)
            report_mismatch("found_mode", 64'(got.mode), 64'(want.mode));
          if (got.nwk_addr !== want.nwk_addr)
            report_mismatch("found_short", 64'(got.nwk_addr), 64'(want.nwk_addr));
          if (got.ieee_addr !== want.ieee_addr)
            report_mismatch("found_long", got.ieee_addr, want.ieee_addr);
          if (got.dest_ep !== want.dest_ep)
            report_mismatch("found_endpoint", 64'(got.dest_ep), 64'(want.dest_ep));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        expected_results.push_back(predict_binding(mk_request(
          in_ch.cmd, in_ch.src_endpoint, in_ch.cluster_id, in_ch.addr_mode,
          in_ch.short_address, in_ch.long_address, in_ch.dest_endpoint)));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : receiver
    int n;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_request(bte_request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= r.cmd;
    in_ch.src_endpoint  <= r.src_ep;
    in_ch.cluster_id    <= r.cluster;
    in_ch.addr_mode     <= r.mode;
    in_ch.short_address <= r.nwk_addr;
    in_ch.long_address  <= r.ieee_addr;
    in_ch.dest_endpoint <= r.dest_ep;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic test_directed();
    logic [63:0] ones;
    ones = {64{1'b1}};
    send_request(mk_request(CMD_LOOKUP, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_RSVD, 8'hFF, 16'hFFFF, MODE_RSVD3, 16'hFFFF, ones, 8'hFF));
    send_request(mk_request(CMD_UNBIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_BIND, 8'hFF, 16'hFFFF, MODE_EXT, 16'hFFFF, ones, 8'hFF));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, ones, 8'hFF));
    send_request(mk_request(CMD_BIND, 8'hFF, 16'hFFFF, MODE_EXT, 16'h0000, ones, 8'hFF));
    send_request(mk_request(CMD_LOOKUP, 8'h00, 16'h0000, MODE_EXT, 16'hFFFF, ones, 8'hFF));
    send_request(mk_request(CMD_LOOKUP, 8'hFF, 16'hFFFF, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_RSVD2, 16'h1234, 64'd5, 8'h01));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_RSVD2, 16'h1234, 64'd5, 8'h01));
    send_request(mk_request(CMD_BIND, 8'h5A, 16'hA55A, MODE_RSVD3, 16'h00FF, ones, 8'h80));
    send_request(mk_request(CMD_UNBIND, 8'h00, 16'h0000, MODE_RSVD2, 16'h1234, 64'd5, 8'h01));
    send_request(mk_request(CMD_UNBIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0001, 64'd0, 8'h00));
    send_request(mk_request(CMD_UNBIND, 8'hFF, 16'hFFFF, MODE_EXT, 16'hFFFF, ones, 8'hFE));
    send_request(mk_request(CMD_UNBIND, 8'hFF, 16'hFFFF, MODE_EXT, 16'hFFFF, ones - 1, 8'hFF));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_EXT, 16'h0000, 64'h8000_0000_0000_0001,
                            8'h7F));
    send_request(mk_request(CMD_LOOKUP, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_UNBIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, ones, 8'h33));
    send_request(mk_request(CMD_LOOKUP, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_RSVD, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_LOOKUP, 8'hFF, 16'hFFFF, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
  endtask

  task automatic test_table_full();
    bte_request_t r;
    bte_request_t filled [$];
    for (int n = 0; n < ENTRIES - 4; n++) begin
      r         = rand_fields();
      r.mode[1] = 1'b0;
      filled.push_back(r);
      send_request(r);
    end
    r      = rand_fields();
    r.mode = MODE_RSVD3;
    send_request(r);
    send_request(mk_request(CMD_BIND, 8'h00, 16'h0000, MODE_GROUP, 16'h0000, 64'd0, 8'h00));
    send_request(mk_request(CMD_LOOKUP, filled[0].src_ep, filled[0].cluster, MODE_GROUP,
                            16'h0000, 64'd0, 8'h00));
    foreach (filled[i]) begin
      r     = filled[i];
      r.cmd = CMD_UNBIND;
      send_request(r);
    end
  endtask

  task automatic init_pool();
    logic [7:0]  key_ep [4];
    logic [15:0] key_cl [4];
    int k;
    key_ep[0] = 8'hFF;
    key_cl[0] = 16'hFFFF;
    for (int i = 1; i < 4; i++) begin
      key_ep[i] = 8'($urandom);
      key_cl[i] = 16'($urandom);
    end
    for (int i = 0; i < POOL_N; i++) begin
      k = $urandom_range(0, 3);
      binding_pool[i]         = rand_fields();
      binding_pool[i].src_ep  = key_ep[k];
      binding_pool[i].cluster = key_cl[k];
      if ($urandom_range(0, 7) != 0)
        binding_pool[i].mode[1] = 1'b0;
    end
  endtask

  function automatic bte_request_t random_request(int bind_w);
    bte_request_t r;
    logic [$bits(bte_request_t)-1:0] flat;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      r = rand_fields();
    else
      r = binding_pool[$urandom_range(0, POOL_N - 1)];
    if (pick < bind_w)
      r.cmd = CMD_BIND;
    else if (pick < 85)
      r.cmd = CMD_UNBIND;
    else if (pick < 97)
      r.cmd = CMD_LOOKUP;
    else
      r.cmd = CMD_RSVD;
    if (r.cmd == CMD_UNBIND && $urandom_range(0, 7) == 0) begin
      flat = r;
      k_flip: begin
        int idx;
        idx = $urandom_range(0, $bits(bte_request_t) - 3);
        flat[idx] = ~flat[idx];
      end
      r = flat;
    end
    // hold back unremovable bindings so the table keeps room to turn over
    if (r.cmd == CMD_BIND && r.mode[1] && count_bound(1'b0) < ENTRIES &&
        count_bound(1'b1) >= PARKED_MAX)
      r.mode[1] = 1'b0;
    return r;
  endfunction

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int n = 0; n < 10; n++)
      send_request(random_request(50));
  endtask

  task automatic test_random(int count);
    int bind_w;
    bind_w = 70;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        bind_w  = ((n / 50) % 2 == 0) ? 70 : 25;
        no_idle = ((n / 50) % 4 == 3);
      end
      send_request(random_request(bind_w));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_BIND;
    in_ch.src_endpoint  = '0;
    in_ch.cluster_id    = '0;
    in_ch.addr_mode     = MODE_GROUP;
    in_ch.short_address = '0;
    in_ch.long_address  = '0;
    in_ch.dest_endpoint = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    init_pool();
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(490);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
